>>> hdl/brfifo_pkg.sv
// ----------------------------------------------------------------------------
// brfifo_pkg
// Types and fixed constants of the circular byte FIFO with drop statistics.
// ----------------------------------------------------------------------------
package brfifo_pkg;

  localparam int unsigned DataW     = 8;
  localparam int unsigned RingSizeW = 13;
  localparam int unsigned FillW     = 12;
  localparam int unsigned CountOutW = 48;

  localparam logic [RingSizeW-1:0] RingSizeReset = 13'd4096;
  localparam logic [RingSizeW-1:0] RingSizeMin   = 13'd2;

  // Item kinds.
  localparam logic KindWrite = 1'b0;
  localparam logic KindRead  = 1'b1;

  typedef struct packed {
    logic             kind;
    logic [DataW-1:0] data_in;
  } item_t;

  typedef struct packed {
    logic [DataW-1:0]     data_out;
    logic                 data_valid;
    logic                 write_accepted;
    logic [FillW-1:0]     fill_level;
    logic [FillW-1:0]     high_water;
    logic [CountOutW-1:0] bytes_captured;
    logic [CountOutW-1:0] bytes_delivered;
    logic [CountOutW-1:0] bytes_dropped;
  } result_t;

endpackage

>>> hdl/byte_ring_fifo_with_drop_stats_top.sv
// ----------------------------------------------------------------------------
// byte_ring_fifo_with_drop_stats_top
// Circular byte FIFO, one slot kept empty, with capture, delivery and drop
// counters and a high-water mark of the fill level.
// ----------------------------------------------------------------------------
//
//  channel   | handshake                  | payload
//  ----------+----------------------------+---------------------------------
//  item in   | start, busy                | item_i   (brfifo_pkg::item_t)
//  result    | done_o (one-cycle strobe)  | result_o (brfifo_pkg::result_t)
//  config    | cfg_valid_i, cfg_ready_o   | cfg_data_i (ring size)
//
// One item is accepted per cycle while busy is low; its result strobe comes in the cycle after
// acceptance, when the byte store's registered read data is available.
// Indices, fill count and counters update at the accepting edge, so each item
// sees the state left by the one before. busy is high only while a
// configuration write is offered; a write empties the FIFO. Reset needs no
// clearing pass: the store holds no valid bits. The receiver cannot stall.
// ----------------------------------------------------------------------------
module byte_ring_fifo_with_drop_stats_top #(
  parameter int unsigned STORE_DEPTH = 4096,
  parameter int unsigned COUNT_WIDTH = 48
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start,
  output logic                                  busy,
  input  brfifo_pkg::item_t                     item_i,
  output logic                                  done_o,
  output brfifo_pkg::result_t                   result_o,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [brfifo_pkg::RingSizeW-1:0]      cfg_data_i
);

  localparam int unsigned AW   = $clog2(STORE_DEPTH);
  localparam int unsigned SW   = AW + 1;
  localparam int unsigned CmpW = (SW > brfifo_pkg::RingSizeW) ? SW : brfifo_pkg::RingSizeW;
  localparam logic [COUNT_WIDTH-1:0] CountMax = '1;

  function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] c);
    sat_inc = (c == CountMax) ? c : c + COUNT_WIDTH'(1);
  endfunction

  logic [brfifo_pkg::RingSizeW-1:0] ring_q;
  logic [AW-1:0]                    wr_idx_q, rd_idx_q;
  logic [AW-1:0]                    fill_q, peak_q;
  logic [COUNT_WIDTH-1:0]           cap_q, dlv_q, drp_q;
  logic                             done_q;
  brfifo_pkg::result_t              res_q;
  logic [brfifo_pkg::DataW-1:0]     byte_store_q [STORE_DEPTH];
  logic [brfifo_pkg::DataW-1:0]     rdata_q;

  logic                             cfg_wr, item_acc;
  logic [CmpW-1:0]                  ring_ext, depth_ext, slots_full;
  logic [SW-1:0]                    slots;
  logic                             wr_ok, rd_ok;
  logic [SW-1:0]                    wr_nxt, rd_nxt;
  logic [AW-1:0]                    fill_d, peak_d, wr_idx_d, rd_idx_d;
  logic [COUNT_WIDTH-1:0]           cap_d, dlv_d, drp_d;

  assign cfg_ready_o = 1'b1;
  assign busy        = cfg_valid_i;
  assign cfg_wr      = cfg_valid_i & cfg_ready_o;
  assign item_acc    = start & ~busy;

  // Effective slot count: the ring size capped at the store depth, zero when
  // the FIFO is disabled by a size below two.
  always_comb begin
    ring_ext   = CmpW'(ring_q);
    depth_ext  = CmpW'(STORE_DEPTH);
    slots_full = (ring_ext > depth_ext) ? depth_ext : ring_ext;
    slots      = (ring_q < brfifo_pkg::RingSizeMin) ? '0 : SW'(slots_full);
  end

  always_comb begin
    wr_ok  = (item_i.kind == brfifo_pkg::KindWrite) && (slots != '0) &&
             ((SW'(fill_q) + SW'(1)) < slots);
    rd_ok  = (item_i.kind == brfifo_pkg::KindRead) && (fill_q != '0);
    wr_nxt = SW'(wr_idx_q) + SW'(1);
    rd_nxt = SW'(rd_idx_q) + SW'(1);

    wr_idx_d = wr_idx_q;
    rd_idx_d = rd_idx_q;
    fill_d   = fill_q;
    peak_d   = peak_q;
    cap_d    = cap_q;
    dlv_d    = dlv_q;
    drp_d    = drp_q;

    if (item_i.kind == brfifo_pkg::KindWrite) begin
      cap_d = sat_inc(cap_q);
      if (wr_ok) begin
        wr_idx_d = (wr_nxt == slots) ? '0 : AW'(wr_nxt);
        fill_d   = fill_q + AW'(1);
        if (fill_d > peak_q) begin
          peak_d = fill_d;
        end
      end else begin
        drp_d = sat_inc(drp_q);
      end
    end else if (rd_ok) begin
      rd_idx_d = (rd_nxt == slots) ? '0 : AW'(rd_nxt);
      fill_d   = fill_q - AW'(1);
      dlv_d    = sat_inc(dlv_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ring_q   <= brfifo_pkg::RingSizeReset;
      wr_idx_q <= '0;
      rd_idx_q <= '0;
      fill_q   <= '0;
      peak_q   <= '0;
      cap_q    <= '0;
      dlv_q    <= '0;
      drp_q    <= '0;
      done_q   <= 1'b0;
    end else begin
      done_q <= item_acc;
      if (cfg_wr) begin
        ring_q   <= cfg_data_i;
        wr_idx_q <= '0;
        rd_idx_q <= '0;
        fill_q   <= '0;
      end else if (item_acc) begin
        wr_idx_q <= wr_idx_d;
        rd_idx_q <= rd_idx_d;
        fill_q   <= fill_d;
        peak_q   <= peak_d;
        cap_q    <= cap_d;
        dlv_q    <= dlv_d;
        drp_q    <= drp_d;
      end
    end
  end

  // Result snapshot; the byte itself comes from the store's read register, loaded at the same edge.
  always_ff @(posedge clk_i) begin
    if (item_acc) begin
      res_q.data_out        <= '0;
      res_q.data_valid      <= rd_ok;
      res_q.write_accepted  <= wr_ok;
      res_q.fill_level      <= brfifo_pkg::FillW'(fill_d);
      res_q.high_water      <= brfifo_pkg::FillW'(peak_d);
      res_q.bytes_captured  <= brfifo_pkg::CountOutW'(cap_d);
      res_q.bytes_delivered <= brfifo_pkg::CountOutW'(dlv_d);
      res_q.bytes_dropped   <= brfifo_pkg::CountOutW'(drp_d);
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_acc && wr_ok) begin
      byte_store_q[wr_idx_q] <= item_i.data_in;
    end
    if (item_acc && rd_ok) begin
      rdata_q <= byte_store_q[rd_idx_q];
    end
  end

  assign done_o = done_q;

  always_comb begin
    result_o          = res_q;
    result_o.data_out = res_q.data_valid ? rdata_q : '0;
  end

  // Assertions.
  a_fill_below_slots: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (slots != '0) |-> (SW'(fill_q) < slots))
    else $error("fill count reached the slot count");

  a_disabled_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (slots == '0) |-> (fill_q == '0))
    else $error("disabled FIFO holds bytes");

  a_done_follows_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
      done_o |-> $past(item_acc))
    else $error("result strobe without an accepted item");

  a_one_outcome: assert property (@(posedge clk_i) disable iff (!rst_ni)
      done_o |-> !(result_o.data_valid && result_o.write_accepted))
    else $error("result both delivers and stores a byte");

  a_peak_covers_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (item_acc && wr_ok) |=> (peak_q >= fill_q))
    else $error("high-water mark below fill after a stored write");

endmodule
